// ===== rtl/binary_frame_sync_checksum_parser_defines.svh =====
// Assertion macros shared by the frame parser RTL.
`ifndef BINARY_FRAME_SYNC_CHECKSUM_PARSER_DEFINES_SVH
`define BINARY_FRAME_SYNC_CHECKSUM_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define BFSC_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("bfsc check failed");
`define BFSC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("bfsc check failed");
`else
`define BFSC_ASSERT_SAME(label, clk, rst, cond, prop)
`define BFSC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== rtl/bfsc_pkg.sv =====
// Shared types and constants for the binary frame parser.
`default_nettype none
package bfsc_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 128;

   localparam int POS_FIELD_W  = 8;
   localparam int PLEN_FIELD_W = 7;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 8;

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   localparam logic [7:0] FIRST_CLASS_RESET  = 8'h01;
   localparam logic [7:0] FIRST_IDENT_RESET  = 8'h07;
   localparam logic [7:0] SECOND_CLASS_RESET = 8'h0A;
   localparam logic [7:0] SECOND_IDENT_RESET = 8'h04;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_CLASS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_IDENT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_CLASS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_IDENT = 2'd3;

   typedef struct packed {
      logic [7:0] first_class;
      logic [7:0] first_ident;
      logic [7:0] second_class;
      logic [7:0] second_ident;
   } cfg_type;

   typedef struct packed {
      logic [POS_FIELD_W-1:0]  byte_position;
      logic                    byte_stored;
      logic                    frame_end;
      logic                    checksum_ok;
      logic [PLEN_FIELD_W-1:0] payload_length;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/binary_frame_sync_checksum_parser.sv =====
// Binary frame parser: takes one received byte per word and reports where it
// landed in a frame (sync B5 62, class, id, 16-bit little-endian length, payload,
// two Fletcher checksum bytes). Each accepted word gives exactly one response
// word, registered in the cycle after acceptance; a new word can be taken every
// cycle as long as the response side keeps up, since a single output register
// separates the two sides. While rsp_stall holds a response word, req_stall is
// raised and the input waits. Frames whose declared length is BUFFER_BYTES or
// more are dropped at the first body byte. The user writes the class and id
// choices through the csr port while the link is idle; the block does not check.
`default_nettype none
`include "binary_frame_sync_checksum_parser_defines.svh"
module binary_frame_sync_checksum_parser #(
   parameter int BUFFER_BYTES = bfsc_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output wire logic                                req_stall,
   input  wire logic [7:0]                          req_rx_byte,
   output wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output wire logic [bfsc_pkg::POS_FIELD_W-1:0]    rsp_byte_position,
   output wire logic                                rsp_byte_stored,
   output wire logic                                rsp_frame_end,
   output wire logic                                rsp_checksum_ok,
   output wire logic [bfsc_pkg::PLEN_FIELD_W-1:0]   rsp_payload_length,
   input  wire logic                                csr_write_enable,
   input  wire logic [bfsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bfsc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   bfsc_pkg::cfg_type cfg;
   bfsc_pkg::rsp_type rsp_next;
   bfsc_pkg::rsp_type rsp_word;
   logic              req_take;

   assign req_stall = rsp_valid & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   bfsc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bfsc_core #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (req_take),
      .rx_byte (req_rx_byte),
      .cfg     (cfg),
      .rsp     (rsp_next)
   );

   bfsc_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (req_take),
      .rsp_next  (rsp_next),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_byte_position  = rsp_word.byte_position;
   assign rsp_byte_stored    = rsp_word.byte_stored;
   assign rsp_frame_end      = rsp_word.frame_end;
   assign rsp_checksum_ok    = rsp_word.checksum_ok;
   assign rsp_payload_length = rsp_word.payload_length;

   `BFSC_ASSERT_NEXT(a_word_gives_rsp, clock, reset, req_take, rsp_valid)
   `BFSC_ASSERT_SAME(a_ok_only_at_end, clock, reset, rsp_valid && rsp_checksum_ok,
      rsp_frame_end && rsp_byte_stored)
   `BFSC_ASSERT_SAME(a_drop_is_clean, clock, reset, rsp_valid && !rsp_byte_stored,
      rsp_byte_position == '0 && !rsp_frame_end)

endmodule
`default_nettype wire

// ===== rtl/bfsc_csr.sv =====
// Configuration registers for the accepted class and id choices.
`default_nettype none
module bfsc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [bfsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bfsc_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output      bfsc_pkg::cfg_type                  cfg
);

   bfsc_pkg::cfg_type cfg_ff;
   bfsc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            bfsc_pkg::CSR_FIRST_CLASS:  cfg_in.first_class  = csr_write_data;
            bfsc_pkg::CSR_FIRST_IDENT:  cfg_in.first_ident  = csr_write_data;
            bfsc_pkg::CSR_SECOND_CLASS: cfg_in.second_class = csr_write_data;
            bfsc_pkg::CSR_SECOND_IDENT: cfg_in.second_ident = csr_write_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_class  <= bfsc_pkg::FIRST_CLASS_RESET;
         cfg_ff.first_ident  <= bfsc_pkg::FIRST_IDENT_RESET;
         cfg_ff.second_class <= bfsc_pkg::SECOND_CLASS_RESET;
         cfg_ff.second_ident <= bfsc_pkg::SECOND_IDENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/bfsc_core.sv =====
// Frame position tracker, running Fletcher sums and per-word result logic.
`default_nettype none
module bfsc_core #(
   parameter int BUFFER_BYTES = bfsc_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        rx_byte,
   input  wire bfsc_pkg::cfg_type cfg,
   output      bfsc_pkg::rsp_type rsp
);

   localparam int POS_W = $clog2(BUFFER_BYTES + 8);
   localparam int LEN_W = $clog2(BUFFER_BYTES);

   localparam logic [POS_W-1:0] POS_SYNC1  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_SYNC2  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_CLASS  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_IDENT  = POS_W'(3);
   localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(4);
   localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(5);
   localparam logic [POS_W-1:0] POS_BODY   = POS_W'(6);
   localparam logic [15:0]      LEN_LIMIT  = 16'(BUFFER_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       sum_a_ff, sum_a_in;
   logic [7:0]       sum_b_ff, sum_b_in;
   logic             ck_a_ok_ff, ck_a_ok_in;
   logic [15:0]      len_word_ff, len_word_in;

   logic             hdr_match;
   logic [7:0]       sum_a_add;
   logic [7:0]       sum_b_add;
   logic [LEN_W-1:0] eff_len;
   logic [POS_W-1:0] body_end;
   logic [POS_W-1:0] pos_next;
   logic [15:0]      pos_wide;
   logic [15:0]      len_wide;
   logic             stored;
   logic             frame_end;
   logic             ck_ok;

   assign sum_a_add = sum_a_ff + rx_byte;
   assign sum_b_add = sum_b_ff + sum_a_add;
   assign pos_next  = pos_ff + POS_W'(1);
   // The frame length is latched at the first body word.
   assign eff_len   = (pos_ff == POS_BODY) ? len_word_ff[LEN_W-1:0] : len_ff;
   assign body_end  = POS_BODY + POS_W'(eff_len);

   always_comb begin
      unique case (pos_ff)
         POS_SYNC1: hdr_match = (rx_byte == bfsc_pkg::SYNC_FIRST);
         POS_SYNC2: hdr_match = (rx_byte == bfsc_pkg::SYNC_SECOND);
         POS_CLASS: hdr_match = (rx_byte == cfg.first_class) ||
                                (rx_byte == cfg.second_class);
         POS_IDENT: hdr_match = (rx_byte == cfg.first_ident) ||
                                (rx_byte == cfg.second_ident);
         default:   hdr_match = 1'b0;
      endcase
   end

   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      ck_a_ok_in  = ck_a_ok_ff;
      len_word_in = len_word_ff;
      stored      = 1'b0;
      frame_end   = 1'b0;
      ck_ok       = 1'b0;
      if (pos_ff < POS_LEN_LO) begin
         if (hdr_match) begin
            stored = 1'b1;
            pos_in = pos_next;
            if (pos_ff == POS_SYNC1) begin
               sum_a_in   = '0;
               sum_b_in   = '0;
               ck_a_ok_in = 1'b0;
            end else if (pos_ff != POS_SYNC2) begin
               sum_a_in = sum_a_add;
               sum_b_in = sum_b_add;
            end
         end else begin
            pos_in = POS_SYNC1;
         end
      end else if (pos_ff <= POS_LEN_HI) begin
         stored   = 1'b1;
         pos_in   = pos_next;
         sum_a_in = sum_a_add;
         sum_b_in = sum_b_add;
         if (pos_ff == POS_LEN_LO) begin
            len_word_in = {8'h00, rx_byte};
         end else begin
            len_word_in = {rx_byte, len_word_ff[7:0]};
         end
      end else if ((pos_ff == POS_BODY) && (len_word_ff >= LEN_LIMIT)) begin
         // drop the word: declared length does not fit the buffer
         pos_in = POS_SYNC1;
      end else begin
         stored = 1'b1;
         len_in = eff_len;
         if (pos_ff < body_end) begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            pos_in   = pos_next;
         end else if (pos_ff == body_end) begin
            ck_a_ok_in = (rx_byte == sum_a_ff);
            pos_in     = pos_next;
         end else begin
            frame_end = 1'b1;
            ck_ok     = ck_a_ok_ff && (rx_byte == sum_b_ff);
            pos_in    = POS_SYNC1;
         end
      end
   end

   assign pos_wide = 16'(pos_ff);
   assign len_wide = 16'(eff_len);

   always_comb begin
      rsp.byte_position  = stored ? pos_wide[bfsc_pkg::POS_FIELD_W-1:0] : '0;
      rsp.byte_stored    = stored;
      rsp.frame_end      = frame_end;
      rsp.checksum_ok    = ck_ok;
      rsp.payload_length = ck_ok ? len_wide[bfsc_pkg::PLEN_FIELD_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         len_ff      <= '0;
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
         ck_a_ok_ff  <= 1'b0;
         len_word_ff <= '0;
      end else if (step) begin
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         ck_a_ok_ff  <= ck_a_ok_in;
         len_word_ff <= len_word_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/bfsc_rsp.sv =====
// Result register for the response channel.
`default_nettype none
module bfsc_rsp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire bfsc_pkg::rsp_type rsp_next,
   input  wire logic              rsp_stall,
   output wire logic              rsp_valid,
   output      bfsc_pkg::rsp_type rsp_word
);

   logic              valid_ff, valid_in;
   bfsc_pkg::rsp_type word_ff;

   // hold the word until it is taken, refill in the same cycle
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule
`default_nettype wire
